FILE: design/assert_macros.svh
// assertion macros for the vertex normal accumulator rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define VNA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// next-cycle implication
`define VNA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

FILE: design/vna_pkg.sv
// types and constants for the vertex normal accumulator
// no dependencies
package vna_pkg;
	localparam int SUM_W = 48;
	localparam int CROSS_W = 36;
	localparam int MAG_W = 32;
	localparam int Q_W = 64;
	localparam int NRM_W = 16;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_TRI   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_WR, ST_TR_RD0, ST_TR_RD1, ST_TR_RD2, ST_TR_SUB, ST_TR_MUL,
		ST_TR_CRS, ST_TR_ARD, ST_TR_AWAIT, ST_TR_ADD, ST_TR_AWR, ST_RD_REQ,
		ST_RD_WAIT, ST_RD_MAG, ST_RD_SHF, ST_RD_SQ, ST_RD_QSUM, ST_RD_SQRT,
		ST_RD_DIV, ST_RD_OUT
	} bk_state_t;

	typedef struct packed {
		logic [NRM_W-1:0] nx;
		logic [NRM_W-1:0] ny;
		logic [NRM_W-1:0] nz;
		logic             zero;
	} result_t;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [CROSS_W-1:0] b
	);
		logic signed [SUM_W:0] r;
		r = {a[SUM_W-1], a} + (SUM_W+1)'(b);
		if (r[SUM_W] != r[SUM_W-1])
			return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		return r[SUM_W-1:0];
	endfunction
endpackage

FILE: design/vna_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
module vna_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: design/vna_front.sv
// front end: accepts commands, drops unused ones and out-of-range writes and triangles, queues the rest
// uses vna_pkg
module vna_front import vna_pkg::*; #(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_BITS = 16,
	parameter int CMD_W = 80
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] in_cmd,
	output logic             q_valid,
	input  logic             q_ready,
	output logic [CMD_W-1:0] q_cmd
);
	localparam int DEPTH = 2;
	logic [CMD_W-1:0] buf_q [DEPTH];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic [1:0]       act;
	logic [9:0]       ia, ib, ic;
	logic             keep, push, pop;

	assign act = in_cmd[1:0];
	assign ia = in_cmd[11:2];
	assign ib = in_cmd[69:60];
	assign ic = in_cmd[79:70];
	always_comb begin
		case (action_t'(act))
			ACT_WRITE: keep = 32'(ia) < MAX_VERTICES;
			ACT_TRI:   keep = 32'(ia) < MAX_VERTICES && 32'(ib) < MAX_VERTICES
				&& 32'(ic) < MAX_VERTICES;
			ACT_READ:  keep = 1'b1;
			default:   keep = 1'b0;
		endcase
	end
	assign in_ready = cnt_q != 2'(DEPTH);
	assign push = in_valid && in_ready && keep;
	assign q_valid = cnt_q != 2'd0;
	assign q_cmd = buf_q[rp_q];
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
	always_ff @(posedge clk) begin
		if (push)
			buf_q[wp_q] <= in_cmd;
	end
endmodule

FILE: design/vna_back.sv
// back end: vertex and sum memories, cross product, normalisation sequencer
// uses vna_pkg, vna_ram, assert_macros.svh
`include "assert_macros.svh"
module vna_back import vna_pkg::*; #(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_BITS = 16,
	parameter int CMD_W = 80
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  logic [CMD_W-1:0] q_cmd,
	output logic             out_valid,
	input  logic             out_ready,
	output result_t          out_res
);
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int VW = 3 * COORD_BITS;
	localparam int DW = COORD_BITS + 1;

	bk_state_t st_q, st_d;
	logic [CMD_W-1:0] cmd_q;
	logic [1:0] k_q;
	logic [5:0] it_q;
	logic signed [COORD_BITS-1:0] va_q [3], vb_q [3];
	logic signed [DW-1:0] e1_q [3], e2_q [3];
	logic signed [2*DW-1:0] p_q [6];
	logic signed [CROSS_W-1:0] n_q [3];
	logic signed [SUM_W-1:0] s_q [3];
	logic [SUM_W-1:0] m_q [3];
	logic [Q_W-1:0] sq_q [3];
	logic [Q_W-1:0] rem_q, root_q, bit_q;
	logic [MAG_W-1:0] len_q;
	logic [MAG_W+16:0] num_q, dvr_q;
	logic [16:0] quo_q;
	logic [NRM_W-1:0] nr_q [3];
	result_t out_q;
	logic rvalid_q;

	logic v_we, s_we;
	logic [AW-1:0] v_ra, s_ra, v_wa, s_wa;
	logic [VW-1:0] v_wd, v_rd;
	logic [3*SUM_W-1:0] s_wd, s_rd;
	logic [AW-1:0] corner;

	assign corner = k_q == 2'd0 ? AW'(cmd_q[2+:10])
		: (k_q == 2'd1 ? AW'(cmd_q[60+:10]) : AW'(cmd_q[70+:10]));

	vna_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vram (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
	vna_ram #(.WIDTH(3*SUM_W), .DEPTH(MAX_VERTICES)) u_sram (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

	assign v_we = st_q == ST_WR;
	assign v_wa = AW'(cmd_q[2+:10]);
	assign v_wd = {cmd_q[44+:COORD_BITS], cmd_q[28+:COORD_BITS], cmd_q[12+:COORD_BITS]};
	assign v_ra = corner;
	assign s_we = st_q == ST_WR || st_q == ST_TR_AWR;
	assign s_wa = st_q == ST_WR ? AW'(cmd_q[2+:10]) : corner;
	assign s_wd = st_q == ST_WR ? '0 : {s_q[2], s_q[1], s_q[0]};
	assign s_ra = st_q == ST_RD_REQ ? AW'(cmd_q[2+:10]) : corner;
	assign q_ready = st_q == ST_IDLE;
	assign out_valid = rvalid_q;
	assign out_res = out_q;

	logic [SUM_W-1:0] mx;
	logic [Q_W-1:0] trial;
	logic [MAG_W+16:0] ntry;
	assign mx = (m_q[0] > m_q[1] ? (m_q[0] > m_q[2] ? m_q[0] : m_q[2])
		: (m_q[1] > m_q[2] ? m_q[1] : m_q[2]));
	assign trial = root_q + bit_q;
	assign ntry = num_q - (dvr_q << it_q);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (q_valid) begin
				case (action_t'(q_cmd[1:0]))
					ACT_WRITE: st_d = ST_WR;
					ACT_TRI:   st_d = ST_TR_RD0;
					ACT_READ:  st_d = ST_RD_REQ;
					default:   st_d = ST_IDLE;
				endcase
			end
			ST_WR:      st_d = ST_IDLE;
			ST_TR_RD0:  st_d = ST_TR_RD1;
			ST_TR_RD1:  st_d = ST_TR_RD2;
			ST_TR_RD2:  st_d = ST_TR_SUB;
			ST_TR_SUB:  st_d = ST_TR_MUL;
			ST_TR_MUL:  st_d = ST_TR_CRS;
			ST_TR_CRS:  st_d = ST_TR_ARD;
			ST_TR_ARD:  st_d = ST_TR_AWAIT;
			ST_TR_AWAIT: st_d = ST_TR_ADD;
			ST_TR_ADD:  st_d = ST_TR_AWR;
			ST_TR_AWR:  st_d = k_q == 2'd2 ? ST_IDLE : ST_TR_ARD;
			ST_RD_REQ:  st_d = ST_RD_WAIT;
			ST_RD_WAIT: st_d = ST_RD_MAG;
			ST_RD_MAG:  st_d = ST_RD_SHF;
			ST_RD_SHF:  st_d = mx == '0 ? ST_RD_OUT : (mx[SUM_W-1:MAG_W-1] != '0 ? ST_RD_SHF : ST_RD_SQ);
			ST_RD_SQ:   st_d = ST_RD_QSUM;
			ST_RD_QSUM: st_d = ST_RD_SQRT;
			ST_RD_SQRT: st_d = bit_q == '0 ? ST_RD_DIV : ST_RD_SQRT;
			ST_RD_DIV:  st_d = (it_q == 6'd0 && k_q == 2'd2) ? ST_RD_OUT : ST_RD_DIV;
			ST_RD_OUT:  st_d = (!rvalid_q || out_ready) ? ST_IDLE : ST_RD_OUT;
			default:    st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (rvalid_q && out_ready) rvalid_q <= 1'b0;
			if (st_q == ST_RD_OUT && (!rvalid_q || out_ready)) rvalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				cmd_q <= q_cmd;
				k_q <= 2'd0;
			end
			ST_TR_RD0: k_q <= 2'd1;
			ST_TR_RD1: begin
				k_q <= 2'd2;
				for (int i = 0; i < 3; i++) va_q[i] <= v_rd[i*COORD_BITS+:COORD_BITS];
			end
			ST_TR_RD2: begin
				k_q <= 2'd0;
				for (int i = 0; i < 3; i++) vb_q[i] <= v_rd[i*COORD_BITS+:COORD_BITS];
			end
			ST_TR_SUB: begin
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= DW'(va_q[i]) - DW'(vb_q[i]);
					e2_q[i] <= DW'(va_q[i]) - DW'(signed'(v_rd[i*COORD_BITS+:COORD_BITS]));
				end
			end
			ST_TR_MUL: begin
				p_q[0] <= e1_q[1] * e2_q[2]; p_q[1] <= e1_q[2] * e2_q[1];
				p_q[2] <= e1_q[2] * e2_q[0]; p_q[3] <= e1_q[0] * e2_q[2];
				p_q[4] <= e1_q[0] * e2_q[1]; p_q[5] <= e1_q[1] * e2_q[0];
			end
			ST_TR_CRS: begin
				for (int i = 0; i < 3; i++)
					n_q[i] <= CROSS_W'(p_q[2*i]) - CROSS_W'(p_q[2*i+1]);
			end
			ST_TR_ADD: begin
				for (int i = 0; i < 3; i++)
					s_q[i] <= sat_add(s_rd[i*SUM_W+:SUM_W], n_q[i]);
			end
			ST_TR_AWR: k_q <= k_q + 2'd1;
			ST_RD_MAG: begin
				for (int i = 0; i < 3; i++) begin
					s_q[i] <= 32'(cmd_q[2+:10]) < MAX_VERTICES ? s_rd[i*SUM_W+:SUM_W] : '0;
					m_q[i] <= 32'(cmd_q[2+:10]) < MAX_VERTICES
						? (s_rd[i*SUM_W+SUM_W-1] ? -s_rd[i*SUM_W+:SUM_W] : s_rd[i*SUM_W+:SUM_W])
						: '0;
				end
			end
			ST_RD_SHF: if (mx[SUM_W-1:MAG_W-1] != '0)
				for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
			ST_RD_SQ: for (int i = 0; i < 3; i++)
				sq_q[i] <= Q_W'(m_q[i][MAG_W-2:0]) * Q_W'(m_q[i][MAG_W-2:0]);
			ST_RD_QSUM: begin
				rem_q <= sq_q[0] + sq_q[1] + sq_q[2];
				root_q <= '0;
				bit_q <= Q_W'(1) << 62;
			end
			ST_RD_SQRT: begin
				if (bit_q != '0) begin
					if (rem_q >= trial) begin
						rem_q <= rem_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else
						root_q <= root_q >> 1;
					bit_q <= bit_q >> 2;
				end else begin
					len_q <= root_q[MAG_W-1:0];
					num_q <= (MAG_W+17)'(m_q[0][MAG_W-2:0]) * 32768 + (MAG_W+17)'(root_q[MAG_W-1:0]);
					dvr_q <= (MAG_W+17)'(root_q[MAG_W-1:0]) << 1;
					it_q <= 6'd16;
					quo_q <= '0;
					k_q <= 2'd0;
				end
			end
			ST_RD_DIV: begin
				if (it_q == 6'd0) begin
					// last quotient bit folded in by quo_q_fin
					nr_q[k_q] <= s_q[k_q][SUM_W-1]
						? -(quo_q_fin(quo_q, num_q, dvr_q)) : quo_q_fin(quo_q, num_q, dvr_q);
					if (k_q != 2'd2) begin
						k_q <= k_q + 2'd1;
						it_q <= 6'd16;
						quo_q <= '0;
						num_q <= (MAG_W+17)'(m_q[k_q+2'd1][MAG_W-2:0]) * 32768 + (MAG_W+17)'(len_q);
					end
				end else begin
					if (ntry[MAG_W+16] == 1'b0 && (dvr_q << it_q) >> it_q == dvr_q
							&& num_q >= (dvr_q << it_q)) begin
						num_q <= ntry;
						quo_q <= quo_q | (17'(1) << it_q);
					end
					it_q <= it_q - 6'd1;
				end
			end
			ST_RD_OUT: if (!rvalid_q || out_ready)
				out_q <= '{nx: nr_q[0], ny: nr_q[1], nz: nr_q[2], zero: mx == '0};
			default: ;
		endcase
		if (st_q == ST_RD_SHF && mx == '0)
			for (int i = 0; i < 3; i++) nr_q[i] <= '0;
	end

	function automatic logic [NRM_W-1:0] quo_q_fin(
		input logic [16:0] q, input logic [MAG_W+16:0] n, input logic [MAG_W+16:0] d
	);
		logic [16:0] r;
		r = (n >= d) ? (q | 17'd1) : q;
		return r > 17'd16384 ? NRM_W'(16384) : NRM_W'(r);
	endfunction

	`VNA_ASSERT_IMP(a_out_only_from_read, clk, arst_n, $rose(rvalid_q), $past(st_q) == ST_RD_OUT)
	`VNA_ASSERT_IMP(a_idle_when_ready, clk, arst_n, q_ready, st_q == ST_IDLE)
	`VNA_ASSERT_NXT(a_wr_returns, clk, arst_n, st_q == ST_WR, st_q == ST_IDLE)
	`VNA_ASSERT_NXT(a_out_held, clk, arst_n, rvalid_q && !out_ready, rvalid_q && $stable(out_q))
endmodule

FILE: design/vertex_normal_accumulator.sv
// top level of the vertex normal accumulator
// uses vna_pkg, vna_front, vna_back
//
// one command stream in (s_axis), one result stream out (m_axis)
// s_axis_tdata: action, vertex_index, coord_x/y/z, corner_b, corner_c
// actions: write vertex (stores coords, clears its sum), add triangle
// (cross product added with 48-bit saturation to three corner sums),
// read normal (returns Q1.14 unit normal and a zero flag on m_axis)
// out-of-range writes and triangles and the unused action are dropped in the front end
// a two-entry command queue parts the front end from the sequencer
// the sequencer takes a request off the queue only when idle, so one request ends
// before the next begins; a triangle does three read-modify-writes, one per
// corner, on the single sum memory; a read runs up to 17 shift steps, the
// bit-serial root (32 steps plus one) and three 17-step restoring divides,
// while a zero sum skips the root and the divides
// reset clears the queue and sequencer; the memories are not cleared
// a stalled receiver holds the result; the sequencer waits in its last
// state until the output register frees, the queue keeps filling meanwhile
module vertex_normal_accumulator import vna_pkg::*; #(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// action[1:0] vertex_index[11:2] coord_x[27:12] coord_y[43:28]
	// coord_z[59:44] corner_b[69:60] corner_c[79:70]
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// normal_x[15:0] normal_y[31:16] normal_z[47:32]
	output logic [47:0] m_axis_tdata,
	// zero_normal
	output logic        m_axis_tuser
);
	localparam int CMD_W = 80;
	logic             q_valid, q_ready;
	logic [CMD_W-1:0] q_cmd, in_cmd;
	result_t          res;

	// internal layout: coords at fixed 16-bit slots, sign extended from COORD_BITS
	assign in_cmd = {s_axis_tdata[79:60],
		16'(signed'(s_axis_tdata[44+:COORD_BITS])),
		16'(signed'(s_axis_tdata[28+:COORD_BITS])),
		16'(signed'(s_axis_tdata[12+:COORD_BITS])),
		s_axis_tdata[11:0]};

	vna_front #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS), .CMD_W(CMD_W)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

	vna_back #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS), .CMD_W(CMD_W)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res));

	assign m_axis_tdata = {res.nz, res.ny, res.nx};
	assign m_axis_tuser = res.zero;
endmodule

FILE: dv/tb.sv
// self-checking testbench for the vertex normal accumulator
// depends on vna_pkg and the vertex_normal_accumulator rtl
// drives vertex, triangle and normal requests, predicts every normal read
module tb;
	import vna_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NVERT = 1024;
	localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam longint CYCLE_LIMIT = 6_000_000;

	typedef struct {
		action_t            act;
		logic [9:0]         idx;
		logic signed [15:0] x, y, z;
		logic [9:0]         cb, cc;
	} request_t;

	typedef struct {
		logic [15:0] nx, ny, nz;
		logic        zero;
	} normal_t;

	// mirror of the vertex and normal-sum stores, plus the queue of pending reads
	class normal_scoreboard;
		longint  vx[NVERT], vy[NVERT], vz[NVERT];
		longint  sx[NVERT], sy[NVERT], sz[NVERT];
		normal_t normals_due[$];
		int      errors;
		int      reads_seen;

		function automatic longint clamp48(longint v);
			if (v > SUM_HI)
				return SUM_HI;
			if (v < SUM_LO)
				return SUM_LO;
			return v;
		endfunction

		function automatic longint unsigned root64(longint unsigned q);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > q)
				b >>= 2;
			while (b != 0) begin
				if (q >= res + b) begin
					q -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function automatic normal_t unit_normal(longint s0, longint s1, longint s2);
			longint unsigned m[3], mx, q, len, v;
			longint          s[3];
			normal_t         n;
			logic [15:0]     o[3];
			s = '{s0, s1, s2};
			for (int i = 0; i < 3; i++)
				m[i] = s[i] < 0 ? -s[i] : s[i];
			mx = m[0];
			if (m[1] > mx) mx = m[1];
			if (m[2] > mx) mx = m[2];
			if (mx == 0) begin
				n = '{16'd0, 16'd0, 16'd0, 1'b1};
				return n;
			end
			// bring magnitudes under 2^31 so the squares fit
			while (mx >= 64'd1 << 31) begin
				mx >>= 1;
				for (int i = 0; i < 3; i++)
					m[i] >>= 1;
			end
			q = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			len = root64(q);
			for (int i = 0; i < 3; i++) begin
				v = (m[i] * 32768 + len) / (2 * len);
				if (v > 16384)
					v = 16384;
				o[i] = s[i] < 0 ? -v[15:0] : v[15:0];
			end
			n = '{o[0], o[1], o[2], 1'b0};
			return n;
		endfunction

		function void note_request(request_t r);
			longint e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
			int     c[3];
			case (r.act)
				ACT_WRITE: begin
					vx[r.idx] = r.x; vy[r.idx] = r.y; vz[r.idx] = r.z;
					sx[r.idx] = 0; sy[r.idx] = 0; sz[r.idx] = 0;
				end
				ACT_TRI: begin
					e1x = vx[r.idx] - vx[r.cb]; e1y = vy[r.idx] - vy[r.cb];
					e1z = vz[r.idx] - vz[r.cb];
					e2x = vx[r.idx] - vx[r.cc]; e2y = vy[r.idx] - vy[r.cc];
					e2z = vz[r.idx] - vz[r.cc];
					cx = e1y * e2z - e1z * e2y;
					cy = e1z * e2x - e1x * e2z;
					cz = e1x * e2y - e1y * e2x;
					// corners in order a, b, c; a repeated corner takes the add twice
					c = '{int'(r.idx), int'(r.cb), int'(r.cc)};
					foreach (c[i]) begin
						sx[c[i]] = clamp48(sx[c[i]] + cx);
						sy[c[i]] = clamp48(sy[c[i]] + cy);
						sz[c[i]] = clamp48(sz[c[i]] + cz);
					end
				end
				ACT_READ:
					normals_due.push_back(unit_normal(sx[r.idx], sy[r.idx], sz[r.idx]));
				default: ;
			endcase
		endfunction

		function void check_normal(logic [47:0] d, logic zf);
			normal_t e;
			if (normals_due.size() == 0) begin
				$error("normal result with none outstanding: %h %b", d, zf);
				errors++;
				return;
			end
			e = normals_due.pop_front();
			reads_seen++;
			if (d[15:0] !== e.nx) begin
				$error("normal_x expected %h got %h", e.nx, d[15:0]); errors++;
			end
			if (d[31:16] !== e.ny) begin
				$error("normal_y expected %h got %h", e.ny, d[31:16]); errors++;
			end
			if (d[47:32] !== e.nz) begin
				$error("normal_z expected %h got %h", e.nz, d[47:32]); errors++;
			end
			if (zf !== e.zero) begin
				$error("zero_normal expected %b got %b", e.zero, zf); errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;

	normal_scoreboard sb;
	bit     vtx_written[NVERT];
	int     written_list[$];
	int     send_gap_pct;
	int     recv_stall_pct;
	int     hold_cycles;
	longint cycle_count;
	int     requests_sent;

	vertex_normal_accumulator u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: long hold-off when asked, otherwise random stalls for the phase
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitors sample the values settled before this edge
	always @(posedge clk) begin
		request_t r;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			r.act = action_t'(s_axis_tdata[1:0]);
			r.idx = s_axis_tdata[11:2];
			r.x = s_axis_tdata[27:12];
			r.y = s_axis_tdata[43:28];
			r.z = s_axis_tdata[59:44];
			r.cb = s_axis_tdata[69:60];
			r.cc = s_axis_tdata[79:70];
			sb.note_request(r);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_normal(m_axis_tdata, m_axis_tuser);
	end

	// offer one request and hold it until taken
	task automatic send_request(request_t r);
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata <= {r.cc, r.cb, r.z, r.y, r.x, r.idx, r.act};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		requests_sent++;
		if (r.act == ACT_WRITE && !vtx_written[r.idx]) begin
			vtx_written[r.idx] = 1'b1;
			written_list.push_back(int'(r.idx));
		end
	endtask

	task automatic put(action_t a, int idx, int x = 0, int y = 0, int z = 0,
			int cb = 0, int cc = 0);
		request_t r;
		r = '{a, idx[9:0], x[15:0], y[15:0], z[15:0], cb[9:0], cc[9:0]};
		send_request(r);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.normals_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_written();
		return written_list[$urandom_range(written_list.size() - 1)];
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(3))
			0: return $urandom_range(15) - 8;
			1: return $urandom_range(1) ? 32767 : -32768;
			default: return $urandom_range(65535) - 32768;
		endcase
	endfunction

	// one random request; indices cluster on a small pool so sums build up
	task automatic random_request();
		request_t r;
		int       k;
		r.idx = 10'($urandom); r.cb = 10'($urandom); r.cc = 10'($urandom);
		r.x = 16'($urandom); r.y = 16'($urandom); r.z = 16'($urandom);
		k = $urandom_range(99);
		if (k < 30 || written_list.size() == 0) begin
			r.act = ACT_WRITE;
			if ($urandom_range(3) != 0)
				r.idx = 10'($urandom_range(31));
			r.x = 16'(rand_coord()); r.y = 16'(rand_coord()); r.z = 16'(rand_coord());
		end else if (k < 72) begin
			r.act = ACT_TRI;
			r.idx = 10'(pick_written()); r.cb = 10'(pick_written());
			r.cc = 10'(pick_written());
		end else if (k < 95) begin
			r.act = ACT_READ;
			r.idx = 10'(pick_written());
		end else begin
			r.act = ACT_NONE;
		end
		send_request(r);
	endtask

	initial begin
		int gap_tab[4];
		int stall_tab[4];
		sb = new();
		cycle_count = 0;
		requests_sent = 0;
		hold_cycles = 0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		gap_tab = '{0, 76, 0, 13};
		stall_tab = '{0, 0, 76, 13};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme coordinates, axis normals, degenerate and repeated corners
		put(ACT_WRITE, 0, 32767, 32767, 0);
		put(ACT_WRITE, 1, -32768, 32767, 0);
		put(ACT_WRITE, 2, 32767, -32768, 0);
		put(ACT_WRITE, 1023, -32768, -32768, -32768);
		put(ACT_READ, 0);                        // fresh vertex reads as zero
		put(ACT_TRI, 0, 0, 0, 0, 1, 2);          // largest +z normal, forces shifting
		put(ACT_READ, 0);
		put(ACT_READ, 1);
		put(ACT_TRI, 0, 0, 0, 0, 2, 1);          // opposite winding cancels
		put(ACT_READ, 2);
		put(ACT_TRI, 1023, 0, 0, 0, 1023, 0);    // repeated corner, zero area
		put(ACT_READ, 1023);
		put(ACT_WRITE, 3, 1, 0, 0);
		put(ACT_WRITE, 4, 0, 1, 0);
		put(ACT_WRITE, 5, 0, 0, 1);
		put(ACT_TRI, 3, 0, 0, 0, 4, 5);          // tiny diagonal normal
		put(ACT_READ, 5);
		put(ACT_TRI, 0, 0, 0, 0, 1, 1023);       // skewed normal, y and z components, x stays zero
		put(ACT_READ, 1023);
		put(ACT_NONE, 1023, -1, -1, -1, 1023, 1023);
		put(ACT_WRITE, 0, -32768, 0, 32767);     // rewrite clears the sum
		put(ACT_READ, 0);
		drain();

		// random phases across the idling mixes
		for (int ph = 0; ph < 4; ph++) begin
			send_gap_pct = gap_tab[ph];
			recv_stall_pct = stall_tab[ph];
			repeat (100)
				random_request();
		end

		// receiver held off while reads keep coming: the queue fills and stalls
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 3000;
		repeat (12)
			put(ACT_READ, pick_written());
		// sender pauses until every normal has come back
		drain();

		// one large triangle repeated so the sums grow well past the shift threshold
		put(ACT_WRITE, 1000, 32767, 32767, 0);
		put(ACT_WRITE, 1001, -32768, 32767, 0);
		put(ACT_WRITE, 1002, 32767, -32768, 0);
		repeat (40)
			put(ACT_TRI, 1000, 0, 0, 0, 1001, 1002);
		put(ACT_READ, 1000);
		put(ACT_TRI, 1000, 0, 0, 0, 1002, 1001); // step back down by one triangle
		put(ACT_READ, 1001);
		put(ACT_READ, 1002);

		send_gap_pct = 13;
		recv_stall_pct = 13;
		repeat (60)
			random_request();

		drain();
		repeat (300) @(posedge clk);
		$display("covered %0d requests and %0d normal reads over four idling mixes,",
			requests_sent, sb.reads_seen);
		$display("a long output hold-off and a run of large accumulated sums");
		if (sb.errors == 0 && sb.normals_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
